FILE: rtl/ll1_pkg.sv
// ll1_pkg: shared types, constants and command/status structs
// for the predictive parse engine; no dependencies
package ll1_pkg;

   localparam int SYM_W      = 5;
   localparam int PROD_W     = 4;
   localparam int POS_W      = 3;
   localparam int LEN_W      = 4;
   localparam int LVL_W      = 7;
   localparam int SP_W       = 6;
   localparam int STACK_DEPTH = 64;
   localparam int RHS_MAX    = 8;
   localparam int CELL_AW    = 2 * SYM_W;
   localparam int CELL_W     = PROD_W + 1;
   localparam int RHS_AW     = PROD_W + POS_W;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_TOKEN = 2'd1,
      REQ_CELL  = 2'd2,
      REQ_RHS   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_MATCHED  = 3'd0,
      ST_ACCEPT   = 3'd1,
      ST_REJECT   = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_WRITTEN  = 3'd4,
      ST_IDLE     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CSR_START = 2'd0,
      CSR_EPS   = 2'd1,
      CSR_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_POP,
      S_TOP,
      S_CELL,
      S_LEN,
      S_PUSH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clear;      // write one cell address of the clearing pass
      logic start;      // reset stack for start request
      logic write_cell;
      logic write_rhs;
      logic load_req;
      logic pop;        // read stack top and decrement count
      logic read_len;   // latch production and its length
      logic push_step;  // handle one rhs position
      logic clr_exp;
      logic inc_exp;
   } ctrl_type;

   typedef struct packed {
      logic clear_done;
      logic stack_empty;
      logic top_match;
      logic tok_end;
      logic top_end;
      logic cell_ok;
      logic limit_hit;
      logic push_done;
      logic push_full;
   } stat_type;

endpackage

FILE: rtl/ll1_ram.sv
// ll1_ram: generic single-port-write ram with registered read
// no dependencies
module ll1_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: rtl/ll1_datapath.sv
// ll1_datapath: table memories, parse stack, counters and csr registers
// depends on ll1_pkg and ll1_ram
module ll1_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ll1_pkg::ctrl_type   ctrl,
   output ll1_pkg::stat_type   stat,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data,
   input  logic [4:0]          req_token,
   input  logic [4:0]          req_row_symbol,
   input  logic [4:0]          req_col_symbol,
   input  logic                req_cell_valid,
   input  logic [3:0]          req_prod_index,
   input  logic [2:0]          req_rhs_pos,
   input  logic [4:0]          req_rhs_symbol,
   input  logic [3:0]          req_rhs_length,
   output logic [7:0]          exp_count,
   output logic [6:0]          stack_level
);
   import ll1_pkg::*;

   logic [SYM_W-1:0]   start_sym_ff, eps_sym_ff;
   logic [7:0]         limit_ff;
   logic [SYM_W-1:0]   tok_ff;
   logic [LVL_W-1:0]   count_ff, count_in;
   logic [7:0]         exp_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [POS_W:0]     pos_ff;   // remaining positions
   logic               bottom_ff;
   logic [CELL_AW-1:0] clr_addr_ff;
   logic [SYM_W-1:0]   top;
   logic [SYM_W-1:0]   stack_rd, stack_wd;
   logic [SP_W-1:0]    stack_wa;
   logic               stack_we;
   logic [CELL_W-1:0]  cell_rd, cell_wd;
   logic               cell_we;
   logic [SYM_W-1:0]   rhs_rd;
   logic [LEN_W-1:0]   len_rd;
   logic [CELL_AW-1:0] cell_ra, cell_wa;
   logic [RHS_AW-1:0]  rhs_ra;
   logic [POS_W-1:0]   pos_m2, len_m1;
   logic [LEN_W-1:0]   len_sat;
   logic               rhs_live, stack_full, push_now;

   // stack entry 0 is never written; top reads as the end marker (0) once a pop reaches level 0
   assign top     = bottom_ff ? '0 : stack_rd;
   assign cell_ra = {top, tok_ff};
   assign cell_we = ctrl.write_cell || ctrl.clear;
   assign cell_wa = ctrl.clear ? clr_addr_ff : {req_row_symbol, req_col_symbol};
   assign cell_wd = ctrl.clear ? '0 : {req_cell_valid, req_prod_index};
   assign pos_m2  = pos_ff[POS_W-1:0] - 2'd2;
   assign len_m1  = len_rd[POS_W-1:0] - 1'b1;
   assign len_sat = (req_rhs_length > LEN_W'(RHS_MAX)) ? LEN_W'(RHS_MAX) : req_rhs_length;

   // rhs read runs one position ahead of the push step
   always_comb begin
      rhs_ra = {prod_ff, pos_m2};
      if (ctrl.read_len) begin
         rhs_ra = {cell_rd[PROD_W-1:0], len_m1};
      end
   end

   ll1_ram #(.WIDTH(CELL_W), .DEPTH(2**CELL_AW)) u_cells (
      .clock, .wr_en(cell_we), .wr_addr(cell_wa),
      .wr_data(cell_wd), .rd_addr(cell_ra), .rd_data(cell_rd));

   ll1_ram #(.WIDTH(SYM_W), .DEPTH(2**RHS_AW)) u_rhs (
      .clock, .wr_en(ctrl.write_rhs), .wr_addr({req_prod_index, req_rhs_pos}),
      .wr_data(req_rhs_symbol), .rd_addr(rhs_ra), .rd_data(rhs_rd));

   ll1_ram #(.WIDTH(LEN_W), .DEPTH(2**PROD_W)) u_len (
      .clock, .wr_en(ctrl.write_rhs), .wr_addr(req_prod_index),
      .wr_data(len_sat), .rd_addr(cell_rd[PROD_W-1:0]), .rd_data(len_rd));

   ll1_ram #(.WIDTH(SYM_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en(stack_we), .wr_addr(stack_wa),
      .wr_data(stack_wd), .rd_addr(count_in[SP_W-1:0]), .rd_data(stack_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         start_sym_ff <= SYM_W'(1);
         eps_sym_ff   <= SYM_W'(1);
         limit_ff     <= 8'd64;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_START: start_sym_ff <= csr_data[SYM_W-1:0];
               CSR_EPS:   eps_sym_ff   <= csr_data[SYM_W-1:0];
               CSR_LIMIT: limit_ff     <= csr_data;
               default: ;
            endcase
         end
         if (ctrl.clear) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // stack and working registers
   assign rhs_live   = (rhs_rd != eps_sym_ff);
   assign stack_full = (count_ff >= LVL_W'(STACK_DEPTH));
   assign push_now   = ctrl.push_step && rhs_live && !stack_full;

   assign stack_we = ctrl.start || push_now;
   assign stack_wa = ctrl.start ? SP_W'(1) : count_ff[SP_W-1:0];
   assign stack_wd = ctrl.start ? start_sym_ff : rhs_rd;

   always_comb begin
      count_in = count_ff;
      if (ctrl.start) begin
         count_in = (start_sym_ff != eps_sym_ff) ? LVL_W'(2) : LVL_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end else if (push_now) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.pop) begin
         bottom_ff <= (count_in == '0);
      end
      if (ctrl.load_req) begin
         tok_ff <= req_token;
      end
      if (ctrl.clr_exp) begin
         exp_ff <= '0;
      end else if (ctrl.inc_exp) begin
         exp_ff <= exp_ff + 1'b1;
      end
      if (ctrl.read_len) begin
         prod_ff <= cell_rd[PROD_W-1:0];
         pos_ff  <= len_rd;
      end else if (ctrl.push_step) begin
         pos_ff  <= pos_ff - 1'b1;
      end
   end

   assign stat.clear_done  = (clr_addr_ff == '1);
   assign stat.stack_empty = (count_ff == '0);
   assign stat.top_match   = (top == tok_ff);
   assign stat.tok_end     = (tok_ff == '0);
   assign stat.top_end     = (top == '0);
   assign stat.cell_ok     = cell_rd[CELL_W-1];
   assign stat.limit_hit   = (exp_ff >= limit_ff);
   assign stat.push_done   = (pos_ff == '0);
   assign stat.push_full   = rhs_live && stack_full;

   assign exp_count   = exp_ff;
   assign stack_level = count_ff;
endmodule

FILE: rtl/ll1_control.sv
// ll1_control: sequencer for requests, pops, expansions and pushes
// depends on ll1_pkg
module ll1_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output ll1_pkg::ctrl_type   ctrl,
   input  ll1_pkg::stat_type   stat
);
   import ll1_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       active_ff, active_in;
   logic       valid_ff, valid_in;
   logic       take;

   assign req_stall  = (state_ff != S_IDLE) || (valid_ff && rsp_stall);
   assign take       = req_valid && !req_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         status_ff <= ST_IDLE;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         valid_ff  <= valid_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      status_in = status_ff;
      valid_in  = valid_ff && rsp_stall;
      ctrl      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ctrl.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take) begin
               ctrl.clr_exp = 1'b1;
               unique case (req_kind_type'(req_type))
                  REQ_START: begin
                     ctrl.start = 1'b1;
                     active_in  = 1'b1;
                     status_in  = ST_MATCHED;
                     state_in   = S_DONE;
                  end
                  REQ_TOKEN: begin
                     ctrl.load_req = 1'b1;
                     if (active_ff) begin
                        state_in = S_POP;
                     end else begin
                        status_in = ST_IDLE;
                        state_in  = S_DONE;
                     end
                  end
                  REQ_CELL: begin
                     ctrl.write_cell = 1'b1;
                     status_in = ST_WRITTEN;
                     state_in  = S_DONE;
                  end
                  REQ_RHS: begin
                     ctrl.write_rhs = 1'b1;
                     status_in = ST_WRITTEN;
                     state_in  = S_DONE;
                  end
                  default: ;
               endcase
            end
         end
         S_POP: begin
            if (stat.stack_empty) begin
               active_in = 1'b0;
               status_in = ST_REJECT;
               state_in  = S_DONE;
            end else begin
               ctrl.pop = 1'b1;
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            priority if (stat.top_match) begin
               status_in = stat.tok_end ? ST_ACCEPT : ST_MATCHED;
               if (stat.tok_end) begin
                  active_in = 1'b0;
               end
               state_in = S_DONE;
            end else if (stat.top_end) begin
               active_in = 1'b0;
               status_in = ST_REJECT;
               state_in  = S_DONE;
            end else begin
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            if (!stat.cell_ok || stat.limit_hit) begin
               active_in = 1'b0;
               status_in = ST_REJECT;
               state_in  = S_DONE;
            end else begin
               ctrl.inc_exp = 1'b1;
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            ctrl.read_len = 1'b1;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            priority if (stat.push_done) begin
               state_in = S_POP;
            end else if (stat.push_full) begin
               active_in = 1'b0;
               status_in = ST_OVERFLOW;
               state_in  = S_DONE;
            end else begin
               ctrl.push_step = 1'b1;
               state_in = S_PUSH;
            end
         end
         S_DONE: begin
            if (!valid_ff || !rsp_stall) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("busy without stall");
   assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> !stat.stack_empty) else $error("pop of empty stack");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !valid_ff) |=> valid_ff) else $error("result lost");
endmodule

FILE: rtl/ll1_predictive_parse_engine.sv
// ll1_predictive_parse_engine: top level of the ll1 table-driven parser
// depends on ll1_pkg, ll1_control, ll1_datapath, ll1_ram
//
// requests arrive on req_* with req_valid/req_stall; one response per request
// leaves on rsp_* with rsp_valid/rsp_stall. a request is taken when valid is
// high and stall low. one request is in flight at a time.
// writes, start and a token with no parse running go from idle to the done
// state, which registers the response. a token goes through the pop and top
// states and, per expansion, the cell, length and push states, as the
// sequencer walks the registered stack, table, length and symbol rams.
// a push step handles one right-hand position, including epsilon positions.
// the next request can be taken in the cycle the response is taken.
// configuration writes on csr_* are always taken (csr_ready high).
// after reset a clearing pass over all 1024 cells marks every cell invalid, with
// req_stall high; the registers go to start 1, epsilon 1, limit 64 and any
// parse stops.
// while rsp_stall is high the response holds and the next request waits.
module ll1_predictive_parse_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [4:0] req_token,
   input  logic [4:0] req_row_symbol,
   input  logic [4:0] req_col_symbol,
   input  logic       req_cell_valid,
   input  logic [3:0] req_prod_index,
   input  logic [2:0] req_rhs_pos,
   input  logic [4:0] req_rhs_symbol,
   input  logic [3:0] req_rhs_length,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_expansions,
   output logic [6:0] rsp_stack_level,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   import ll1_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   assign csr_ready = 1'b1;

   ll1_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_type,
      .rsp_valid, .rsp_stall, .rsp_status, .ctrl, .stat);

   ll1_datapath u_dp (
      .clock, .reset, .ctrl, .stat,
      .csr_we(csr_valid), .csr_index, .csr_data,
      .req_token, .req_row_symbol, .req_col_symbol, .req_cell_valid,
      .req_prod_index, .req_rhs_pos, .req_rhs_symbol, .req_rhs_length,
      .exp_count(rsp_expansions), .stack_level(rsp_stack_level));
endmodule
